>>> rtl/fgpla_pkg.sv
// Package: types, constants and state codes for the fenced page allocator.
`timescale 1ns / 1ps
package fgpla_pkg;
  localparam int PoolPagesDefault = 64;
  localparam logic [24:0] PageSizeReset = 25'd65536;

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_CLEANUP = 1'b1;

  localparam logic [2:0] ST_ALLOC    = 3'd0;
  localparam logic [2:0] ST_LARGE    = 3'd1;
  localparam logic [2:0] ST_EXHAUST  = 3'd2;
  localparam logic [2:0] ST_CLEANED  = 3'd3;
  localparam logic [2:0] ST_NO_PAGE  = 3'd4;

  typedef struct packed {
    logic        kind;
    logic [31:0] request_size;
    logic [4:0]  align_log2;
    logic [31:0] fence_value;
    logic [31:0] completed_fence;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  page_index;
    logic [24:0] byte_offset;
    logic [31:0] block_size;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EVAL, S_DRAIN, S_DRAIN_WAIT, S_TAKE, S_TAKE_WAIT, S_FLUSH, S_FLUSH_RD,
    S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic eval;
    logic drain_rd;
    logic drain_step;
    logic take_rd;
    logic take_step;
    logic flush_rd;
    logic flush_step;
    logic flush_cur;
    logic finish;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_cleanup;
    logic cur_valid;
    logic is_large;
    logic no_fit;
    logic drain_ok;
    logic flush_more;
  } sts_t;
endpackage

>>> rtl/fgpla_ctrl.sv
// Controller state machine for the fenced page allocator.
`timescale 1ns / 1ps
module fgpla_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             out_stall,
  output logic             out_valid,
  input  fgpla_pkg::sts_t  sts,
  output fgpla_pkg::cmd_t  cmd
);
  import fgpla_pkg::*;

  state_t state, state_next;
  logic out_full, out_full_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      out_full <= out_full_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_EVAL;
      S_EVAL: begin
        if (sts.is_cleanup) state_next = sts.cur_valid ? S_FLUSH : S_OUT;
        else if (sts.is_large) state_next = S_OUT;
        else if (sts.no_fit) state_next = S_DRAIN;
        else state_next = S_OUT;
      end
      S_DRAIN: state_next = S_DRAIN_WAIT;
      S_DRAIN_WAIT: state_next = sts.drain_ok ? S_DRAIN : S_TAKE;
      S_TAKE: state_next = S_TAKE_WAIT;
      S_TAKE_WAIT: state_next = S_OUT;
      S_FLUSH: state_next = S_FLUSH_RD;
      S_FLUSH_RD: state_next = sts.flush_more ? S_FLUSH : S_OUT;
      S_OUT: if (!out_full || !out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = (state != S_IDLE);
    out_valid = out_full;
    out_full_next = out_full && out_stall;
    case (state)
      S_IDLE: cmd.load = in_valid;
      S_EVAL: cmd.eval = 1'b1;
      S_DRAIN: cmd.drain_rd = 1'b1;
      S_DRAIN_WAIT: cmd.drain_step = sts.drain_ok;
      S_TAKE: cmd.take_rd = 1'b1;
      S_TAKE_WAIT: cmd.take_step = 1'b1;
      S_FLUSH: cmd.flush_rd = 1'b1;
      S_FLUSH_RD: begin
        cmd.flush_step = sts.flush_more;
        cmd.flush_cur = !sts.flush_more;
      end
      S_OUT: begin
        if (!out_full || !out_stall) begin
          cmd.out_load = 1'b1;
          cmd.finish = 1'b1;
          out_full_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("input taken while busy");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_full && out_stall) |=> out_full) else $error("result lost");
  a_single: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> (state == S_IDLE)) else $error("result path stuck");
endmodule

>>> rtl/fgpla_dp.sv
// Datapath for the fenced page allocator: offsets, page queues, result register.
`timescale 1ns / 1ps
module fgpla_dp #(
  parameter int POOL_PAGES = fgpla_pkg::PoolPagesDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [24:0]       cfg_data,
  input  fgpla_pkg::req_t   req,
  input  fgpla_pkg::cmd_t   cmd,
  output fgpla_pkg::sts_t   sts,
  output fgpla_pkg::rsp_t   rsp
);
  import fgpla_pkg::*;

  localparam int AW = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int CW = $clog2(POOL_PAGES + 1);
  localparam logic [CW-1:0] POOL_FULL = CW'(POOL_PAGES);
  localparam logic [CW:0] POOL_WRAP = (CW+1)'(POOL_PAGES);

  logic [24:0] page_size;
  req_t        r;
  logic [AW-1:0] current_page;
  logic        current_valid;
  logic [24:0] current_offset;

  logic [AW-1:0] pend_mem [POOL_PAGES];
  logic [CW-1:0] pending_count;
  logic [AW-1:0] ret_page_mem [POOL_PAGES];
  logic [31:0]   ret_tag_mem [POOL_PAGES];
  logic [AW-1:0] ret_head;
  logic [CW-1:0] retired_count;
  logic [AW-1:0] free_mem [POOL_PAGES];
  logic [AW-1:0] free_head;
  logic [CW-1:0] free_count;
  logic [CW-1:0] pages_created;
  logic [CW-1:0] flush_idx;

  logic [AW-1:0] ret_rd_page, free_rd, pend_rd;
  logic [31:0]   ret_rd_tag;

  // aligned size and offset, registered at eval
  logic [32:0] mask, asize_w, off_w;
  logic [33:0] end_w;
  logic        oversize_w;
  logic        nofit_w;
  logic [32:0] asize;
  logic [25:0] off;
  logic [2:0]  status;
  logic        got_page;

  assign mask = (33'd1 << r.align_log2) - 33'd1;
  assign asize_w = ({1'b0, r.request_size} + mask) & ~mask;
  assign off_w = ({8'd0, current_offset} + mask) & ~mask;
  assign end_w = {1'b0, off_w} + {1'b0, asize_w};
  assign oversize_w = asize_w > {8'd0, page_size};
  assign nofit_w = !current_valid || (end_w > {9'd0, page_size});

  always_ff @(posedge clk) begin
    if (rst) page_size <= PageSizeReset;
    else if (cfg_we) page_size <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) r <= req;
    if (cmd.eval) begin
      asize <= asize_w;
      off <= current_valid ? 26'(off_w) : 26'd0;
    end
    ret_rd_page <= ret_page_mem[ret_head];
    ret_rd_tag <= ret_tag_mem[ret_head];
    free_rd <= free_mem[free_head];
    pend_rd <= pend_mem[flush_idx[AW-1:0]];
  end

  wire [CW:0] ret_sum = (CW+1)'(ret_head) + (CW+1)'(retired_count);
  wire [CW:0] free_sum = (CW+1)'(free_head) + (CW+1)'(free_count);
  wire [AW-1:0] ret_tail = AW'((ret_sum >= POOL_WRAP) ? ret_sum - POOL_WRAP : ret_sum);
  wire [AW-1:0] free_tail = AW'((free_sum >= POOL_WRAP) ? free_sum - POOL_WRAP : free_sum);

  // page newly taken starts at offset zero
  wire [24:0] out_off = got_page ? 25'd0 : off[24:0];
  logic unused_offmsb;
  assign unused_offmsb = off[25];
  logic unused_cmd;
  assign unused_cmd = cmd.drain_rd ^ cmd.take_rd ^ cmd.flush_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      current_page <= '0;
      current_valid <= 1'b0;
      current_offset <= '0;
      pending_count <= '0;
      ret_head <= '0;
      retired_count <= '0;
      free_head <= '0;
      free_count <= '0;
      pages_created <= '0;
      flush_idx <= '0;
      status <= ST_ALLOC;
      got_page <= 1'b0;
    end else begin
      if (cmd.eval) begin
        flush_idx <= '0;
        got_page <= 1'b0;
        if (r.kind == KIND_CLEANUP) status <= current_valid ? ST_CLEANED : ST_NO_PAGE;
        else if (oversize_w) status <= ST_LARGE;
        else if (current_valid && (end_w > {9'd0, page_size})) begin
          if (pending_count < POOL_FULL) begin
            pend_mem[pending_count[AW-1:0]] <= current_page;
            pending_count <= pending_count + 1'b1;
          end
          current_valid <= 1'b0;
          current_page <= '0;
          status <= ST_ALLOC;
        end else status <= ST_ALLOC;
      end
      if (cmd.drain_step) begin
        if (free_count < POOL_FULL) begin
          free_mem[free_tail] <= ret_rd_page;
          free_count <= free_count + 1'b1;
        end
        ret_head <= (ret_head == AW'(POOL_PAGES - 1)) ? '0 : ret_head + 1'b1;
        retired_count <= retired_count - 1'b1;
      end
      if (cmd.take_step) begin
        current_offset <= '0;
        if (free_count != '0) begin
          current_page <= free_rd;
          current_valid <= 1'b1;
          got_page <= 1'b1;
          free_head <= (free_head == AW'(POOL_PAGES - 1)) ? '0 : free_head + 1'b1;
          free_count <= free_count - 1'b1;
        end else if (pages_created < POOL_FULL) begin
          current_page <= AW'(pages_created);
          current_valid <= 1'b1;
          got_page <= 1'b1;
          pages_created <= pages_created + 1'b1;
        end else begin
          status <= ST_EXHAUST;
        end
      end
      if (cmd.flush_step || cmd.flush_cur) begin
        if (retired_count < POOL_FULL) begin
          ret_page_mem[ret_tail] <= cmd.flush_cur ? current_page : pend_rd;
          ret_tag_mem[ret_tail] <= r.fence_value;
          retired_count <= retired_count + 1'b1;
        end
        flush_idx <= flush_idx + 1'b1;
        if (cmd.flush_cur) begin
          pending_count <= '0;
          current_valid <= 1'b0;
          current_page <= '0;
          current_offset <= '0;
        end
      end
      if (cmd.finish && r.kind == KIND_ALLOC && status == ST_ALLOC && current_valid)
        current_offset <= 25'({1'b0, out_off} + 26'(asize));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.status <= status;
      rsp.page_index <= '0;
      rsp.byte_offset <= '0;
      rsp.block_size <= '0;
      if (r.kind == KIND_ALLOC) begin
        if (status == ST_LARGE)
          rsp.block_size <= asize[32] ? 32'hFFFF_FFFF : asize[31:0];
        else rsp.block_size <= asize[31:0];
        if (status == ST_ALLOC) begin
          rsp.page_index <= 6'(current_page);
          rsp.byte_offset <= out_off;
        end
      end
    end
  end

  // the current offset used at finish for a new page must be zero-based
  assign sts.is_cleanup = (r.kind == KIND_CLEANUP);
  assign sts.cur_valid = current_valid;
  assign sts.is_large = oversize_w;
  assign sts.no_fit = nofit_w;
  assign sts.drain_ok = (retired_count != '0) && (ret_rd_tag <= r.completed_fence);
  assign sts.flush_more = flush_idx < pending_count;

  a_counts: assert property (@(posedge clk) disable iff (rst)
    (pending_count <= POOL_FULL) && (retired_count <= POOL_FULL) && (free_count <= POOL_FULL))
    else $error("queue count overflow");
  a_created: assert property (@(posedge clk) disable iff (rst)
    pages_created <= POOL_FULL) else $error("pool count overflow");
  a_take: assert property (@(posedge clk) disable iff (rst)
    cmd.take_step && got_page == 1'b0 |=> (current_valid || status == ST_EXHAUST))
    else $error("page request lost");
endmodule

>>> rtl/fence_gated_page_linear_allocator.sv
// Top level of the fenced page linear allocator.
`timescale 1ns / 1ps
// Bump allocator over a pool of POOL_PAGES equal pages. Each request gives one
// result. A request that fits the current page passes IDLE, EVAL and OUT; a page
// change adds a DRAIN/DRAIN_WAIT pair per retired page moved to the free queue, a
// last DRAIN/DRAIN_WAIT check, then TAKE and TAKE_WAIT; a cleanup adds a FLUSH/FLUSH_RD
// pair per pending page plus one for the current page. A stalled result holds the
// block until taken. The page queues are read through registers, one entry per state pair.
module fence_gated_page_linear_allocator #(
  parameter int POOL_PAGES = fgpla_pkg::PoolPagesDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [24:0]      cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  fgpla_pkg::req_t  in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output fgpla_pkg::rsp_t  out_data
);
  import fgpla_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fgpla_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_stall, .out_valid, .sts, .cmd
  );

  fgpla_dp #(.POOL_PAGES(POOL_PAGES)) u_dp (
    .clk, .rst, .cfg_we, .cfg_data, .req(in_data), .cmd, .sts, .rsp(out_data)
  );
endmodule

>>> tb/tb_fence_gated_page_linear_allocator.sv
// Testbench for the fenced page linear allocator: queued driver, checking monitor, predictor.
`timescale 1ns / 1ps
module tb_fence_gated_page_linear_allocator;
  import fgpla_pkg::*;

  localparam int NPAGES = 64;
  localparam int WDOG_LIMIT = 20000;

  logic clk, rst, cfg_we, in_valid, in_stall, out_valid, out_stall;
  logic [24:0] cfg_data;
  req_t in_data;
  rsp_t out_data;

  fence_gated_page_linear_allocator DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  req_t request_q[$];
  rsp_t expected_rsp_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  logic [31:0] fence_ctr = 0;

  // allocator shadow state
  logic [24:0] page_sz;
  logic [6:0]  cur_page;
  logic        cur_valid;
  logic [24:0] cur_off;
  logic [6:0]  pend_list[NPAGES];
  int          pend_cnt;
  logic [6:0]  ret_page[NPAGES];
  logic [31:0] ret_tag[NPAGES];
  int          ret_head, ret_cnt;
  logic [6:0]  free_list[NPAGES];
  int          free_head, free_cnt;
  int          created;

  task automatic alloc_reset();
    page_sz = PageSizeReset;
    cur_page = 0; cur_valid = 0; cur_off = 0;
    pend_cnt = 0; ret_head = 0; ret_cnt = 0; free_head = 0; free_cnt = 0; created = 0;
  endtask

  task automatic add_req(input req_t r);
    request_q = {request_q, r};
  endtask

  task automatic retire_page(input logic [6:0] pg, input logic [31:0] tag);
    if (ret_cnt < NPAGES) begin
      ret_page[(ret_head + ret_cnt) % NPAGES] = pg;
      ret_tag[(ret_head + ret_cnt) % NPAGES] = tag;
      ret_cnt++;
    end
  endtask

  task automatic grab_page(input logic [31:0] completed, output logic ok, output logic [6:0] pg);
    while (ret_cnt > 0 && ret_tag[ret_head] <= completed) begin
      if (free_cnt < NPAGES) begin
        free_list[(free_head + free_cnt) % NPAGES] = ret_page[ret_head];
        free_cnt++;
      end
      ret_head = (ret_head + 1) % NPAGES;
      ret_cnt--;
    end
    ok = 1;
    pg = 0;
    if (free_cnt > 0) begin
      pg = free_list[free_head];
      free_head = (free_head + 1) % NPAGES;
      free_cnt--;
    end else if (created < NPAGES) begin
      pg = created[6:0];
      created++;
    end else begin
      ok = 0;
    end
  endtask

  task automatic predict_alloc(input req_t r, output rsp_t o);
    logic [63:0] mask, asize, off;
    logic ok;
    logic [6:0] pg;
    o = '0;
    mask = (64'd1 << r.align_log2) - 64'd1;
    if (r.kind == KIND_CLEANUP) begin
      if (!cur_valid) begin
        o.status = ST_NO_PAGE;
      end else begin
        for (int i = 0; i < pend_cnt; i++) retire_page(pend_list[i], r.fence_value);
        retire_page(cur_page, r.fence_value);
        pend_cnt = 0; cur_valid = 0; cur_page = 0; cur_off = 0;
        o.status = ST_CLEANED;
      end
    end else begin
      asize = ({32'd0, r.request_size} + mask) & ~mask;
      if (asize > {39'd0, page_sz}) begin
        o.status = ST_LARGE;
        o.block_size = (asize > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : asize[31:0];
      end else begin
        off = ({39'd0, cur_off} + mask) & ~mask;
        if (cur_valid && off + asize > {39'd0, page_sz}) begin
          if (pend_cnt < NPAGES) begin
            pend_list[pend_cnt] = cur_page;
            pend_cnt++;
          end
          cur_valid = 0; cur_page = 0;
        end
        ok = 1;
        if (!cur_valid) begin
          off = 0; cur_off = 0;
          grab_page(r.completed_fence, ok, pg);
          if (ok) begin
            cur_page = pg; cur_valid = 1;
          end
        end
        o.block_size = asize[31:0];
        if (!ok) begin
          o.status = ST_EXHAUST;
        end else begin
          o.status = ST_ALLOC;
          o.page_index = cur_page[5:0];
          o.byte_offset = off[24:0];
          cur_off = off[24:0] + asize[24:0];
        end
      end
    end
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    rsp_t e;
    if (rst) begin
      in_valid <= 0;
      in_data <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_alloc(in_data, e);
        expected_rsp_q = {expected_rsp_q, e};
      end
      if (!in_valid || !in_stall) begin
        if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= request_q.pop_front();
          in_valid <= 1;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    rsp_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_rsp_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          errors++;
        end else begin
          e = expected_rsp_q.pop_front();
          if (out_data.status !== e.status)
            $display("%0t: status exp %0d got %0d", $time, e.status, out_data.status);
          if (out_data.page_index !== e.page_index)
            $display("%0t: page exp %0d got %0d", $time, e.page_index, out_data.page_index);
          if (out_data.byte_offset !== e.byte_offset)
            $display("%0t: offset exp %h got %h", $time, e.byte_offset, out_data.byte_offset);
          if (out_data.block_size !== e.block_size)
            $display("%0t: size exp %h got %h", $time, e.block_size, out_data.block_size);
          if (out_data !== e) errors++;
        end
      end
    end
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 600;
      out_stall <= 1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (request_q.size() == 0 && expected_rsp_q.size() == 0 && !in_valid))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic req_t mk_req(input logic k, input logic [31:0] sz, input logic [4:0] lg,
                                  input logic [31:0] fv, input logic [31:0] cf);
    req_t r;
    r.kind = k; r.request_size = sz; r.align_log2 = lg;
    r.fence_value = fv; r.completed_fence = cf;
    return r;
  endfunction

  function automatic req_t rand_req(input logic [24:0] psz);
    req_t r;
    int p;
    r.kind = ($urandom_range(11) == 0) ? KIND_CLEANUP : KIND_ALLOC;
    p = $urandom_range(99);
    if (p < 70) r.request_size = $urandom_range(0, psz / 3);
    else if (p < 90) r.request_size = $urandom_range(0, psz);
    else r.request_size = $urandom;
    p = $urandom_range(99);
    r.align_log2 = (p < 85) ? $urandom_range(0, 8) : (p < 95 ? $urandom_range(0, 16)
                                                              : $urandom_range(0, 31));
    if (r.kind == KIND_CLEANUP) fence_ctr = fence_ctr + 1;
    r.fence_value = ($urandom_range(19) == 0) ? $urandom : fence_ctr;
    p = $urandom_range(99);
    r.completed_fence = (p < 80) ? fence_ctr - $urandom_range(0, 3) :
                        (p < 90 ? 32'hFFFF_FFFF : $urandom);
    return r;
  endfunction

  task automatic drain_all();
    while (request_q.size() > 0 || in_valid || expected_rsp_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_page_size(input logic [24:0] v);
    @(posedge clk);
    cfg_we <= 1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    page_sz = v;
  endtask

  logic [24:0] settings[5] = '{25'd65536, 25'd256, 25'd16777216, 25'd1000, 25'd4096};

  initial begin
    rst = 1; cfg_we = 0; cfg_data = 0;
    alloc_reset();
    repeat (3) @(posedge clk);
    rst <= 0;
    write_page_size(PageSizeReset);

    // directed
    add_req(mk_req(KIND_CLEANUP, 0, 0, 5, 0));                  // cleanup, no page
    add_req(mk_req(KIND_ALLOC, 0, 0, 0, 0));                    // zero size
    add_req(mk_req(KIND_ALLOC, 3, 0, 0, 0));
    add_req(mk_req(KIND_ALLOC, 5, 4, 0, 0));                    // misaligned offset
    add_req(mk_req(KIND_ALLOC, 32'd65536, 0, 0, 0));            // exact page, new page
    add_req(mk_req(KIND_ALLOC, 32'd65537, 0, 0, 0));            // large
    add_req(mk_req(KIND_ALLOC, 32'hFFFF_FFFF, 0, 0, 0));        // large, no wrap
    add_req(mk_req(KIND_ALLOC, 32'hFFFF_FFFF, 31, 0, 0));       // large, saturated
    add_req(mk_req(KIND_ALLOC, 0, 31, 0, 0));                   // huge alignment
    add_req(mk_req(KIND_ALLOC, 1, 16, 0, 0));
    add_req(mk_req(KIND_CLEANUP, 0, 0, 32'hFFFF_FFFF, 0));      // cleanup done
    add_req(mk_req(KIND_ALLOC, 100, 2, 0, 32'hFFFF_FFFE));      // fence not yet done
    add_req(mk_req(KIND_ALLOC, 32'd65536, 0, 0, 32'hFFFF_FFFF));
    add_req(mk_req(KIND_CLEANUP, 0, 0, 32'd0, 0));
    add_req(mk_req(KIND_ALLOC, 32'd65536, 0, 0, 32'hFFFF_FFFF)); // reuse retired pages
    add_req(mk_req(KIND_ALLOC, 32'd65536, 0, 0, 32'd0));
    add_req(mk_req(KIND_ALLOC, 32'd7, 3, 0, 32'd0));
    drain_all();

    foreach (settings[s]) begin
      write_page_size(settings[s]);
      for (int m = 0; m < 4; m++) begin
        case (m)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
          default: begin send_idle_pct = 18; recv_stall_pct = 18; end
        endcase
        for (int i = 0; i < 42; i++) add_req(rand_req(page_sz));
        if (s == 1 && m == 0) hold_req = hold_req + 1;
        drain_all();
      end
    end

    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

>>> files.f
rtl/fgpla_pkg.sv
rtl/fgpla_ctrl.sv
rtl/fgpla_dp.sv
rtl/fence_gated_page_linear_allocator.sv
tb/tb_fence_gated_page_linear_allocator.sv
